// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/trld_pkg.sv
// -----------------------------------------------------------------------------
// trld_pkg
// Types and constants of the TGA run-length pixel decoder.
// -----------------------------------------------------------------------------
`default_nettype none

package trld_pkg;

   localparam logic [7:0] RUN_FLAG   = 8'd128;
   localparam logic [7:0] RUN_BIAS   = 8'd127;
   localparam logic [2:0] WIDE_PIXEL = 3'd4;
   localparam logic [2:0] NARROW_PIXEL = 3'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] CSR_PIXEL_TOTAL     = 2'd1;

   localparam logic [2:0]  BPP_RESET   = 3'd3;
   localparam logic [31:0] TOTAL_RESET = 32'd1;

   typedef struct packed {
      logic [2:0]  bytes_per_pixel;
      logic [31:0] pixel_total;
   } trld_cfg_type;

   // Completed pixel as queued between front and back
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] last_byte;
      logic       wide;
      logic [7:0] repeat_res;
      logic       image_done;
   } trld_item_type;

   // Formatted result
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_res;
      logic       image_done;
   } trld_result_type;

endpackage

`default_nettype wire

// File: rtl/trld_front.sv
// -----------------------------------------------------------------------------
// trld_front
// Packet parser: tracks headers, gathers pixel bytes and counts image pixels.
// -----------------------------------------------------------------------------
`default_nettype none

module trld_front
   import trld_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire trld_cfg_type  cfg,
   input  wire logic          accept,
   input  wire logic [7:0]    data_byte,
   output logic               item_valid,
   output trld_item_type      item
);

   logic        in_packet_ff, in_packet_in;
   logic        run_packet_ff, run_packet_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] done_cnt_ff, done_cnt_in;
   logic [7:0]  pb_ff [3];

   logic        wide;
   logic [2:0]  size;
   logic        pixel_end;
   logic [7:0]  count;
   logic [32:0] diff;
   logic [31:0] remaining;
   logic        last;
   logic [7:0]  left_dec;

   always_comb begin
      wide      = (cfg.bytes_per_pixel == WIDE_PIXEL);
      size      = wide ? WIDE_PIXEL : NARROW_PIXEL;
      pixel_end = ({1'b0, pos_ff} + 3'd1) >= size;
      count     = run_packet_ff ? left_ff : 8'd1;
      if (count == 8'd0) begin
         count = 8'd1;
      end
      diff = {1'b0, cfg.pixel_total} - {1'b0, done_cnt_ff};
      if (!diff[32] && (diff[31:0] != 32'd0)) begin
         remaining = diff[31:0];
      end else begin
         remaining = 32'd1;
      end
      last     = (remaining[31:8] == 24'd0) && (count >= remaining[7:0]);
      left_dec = left_ff - 8'd1;

      in_packet_in  = in_packet_ff;
      run_packet_in = run_packet_ff;
      left_in       = left_ff;
      pos_in        = pos_ff;
      done_cnt_in   = done_cnt_ff;
      item_valid    = 1'b0;

      item.byte0      = pb_ff[0];
      item.byte1      = pb_ff[1];
      item.byte2      = pb_ff[2];
      item.last_byte  = data_byte;
      item.wide       = wide;
      item.repeat_res = last ? remaining[7:0] : count;
      item.image_done = last;

      if (accept) begin
         if (!in_packet_ff) begin
            // header byte opens a packet
            run_packet_in = data_byte >= RUN_FLAG;
            left_in       = (data_byte >= RUN_FLAG) ? data_byte - RUN_BIAS
                                                    : data_byte + 8'd1;
            pos_in        = 2'd0;
            in_packet_in  = 1'b1;
         end else if (!pixel_end) begin
            pos_in = pos_ff + 2'd1;
         end else begin
            item_valid = 1'b1;
            pos_in     = 2'd0;
            if (last) begin
               // image complete: drop rest of packet, expect a header
               in_packet_in  = 1'b0;
               run_packet_in = 1'b0;
               left_in       = 8'd0;
               done_cnt_in   = 32'd0;
            end else begin
               done_cnt_in = done_cnt_ff + {24'd0, count};
               if (run_packet_ff) begin
                  in_packet_in = 1'b0;
                  left_in      = 8'd0;
               end else begin
                  left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     in_packet_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff  <= 1'b0;
         run_packet_ff <= 1'b0;
         left_ff       <= 8'd0;
         pos_ff        <= 2'd0;
         done_cnt_ff   <= 32'd0;
      end else begin
         in_packet_ff  <= in_packet_in;
         run_packet_ff <= run_packet_in;
         left_ff       <= left_in;
         pos_ff        <= pos_in;
         done_cnt_ff   <= done_cnt_in;
      end
   end

   // pixel byte store, no reset
   always_ff @(posedge clock) begin
      if (accept && in_packet_ff && !pixel_end && (pos_ff != 2'd3)) begin
         pb_ff[pos_ff] <= data_byte;
      end
   end

endmodule

`default_nettype wire

// File: rtl/trld_fifo.sv
// -----------------------------------------------------------------------------
// trld_fifo
// Short queue of completed pixels between parser and output stage.
// -----------------------------------------------------------------------------
`default_nettype none

module trld_fifo
   import trld_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire trld_item_type  wr_item,
   input  wire logic           rd_en,
   output trld_item_type       rd_item,
   output logic                full,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   trld_item_type    mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      full    = (cnt_ff == FULL_CNT);
      empty   = (cnt_ff == '0);
      rd_item = mem[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/trld_back.sv
// -----------------------------------------------------------------------------
// trld_back
// Output stage: swaps channels into RGB order and holds the result register.
// -----------------------------------------------------------------------------
`default_nettype none

module trld_back
   import trld_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_empty,
   input  wire trld_item_type  q_item,
   output logic                q_pop,
   input  wire logic           out_pop,
   output logic                out_valid,
   output trld_result_type     out_result
);

   logic            valid_ff, valid_in;
   trld_result_type result_ff, result_in;

   always_comb begin
      // advance when the register is free or being taken
      q_pop    = !q_empty && (!valid_ff || out_pop);
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end

      result_in.red        = q_item.wide ? q_item.byte2 : q_item.last_byte;
      result_in.green      = q_item.byte1;
      result_in.blue       = q_item.byte0;
      result_in.alpha      = q_item.wide ? q_item.last_byte : 8'd0;
      result_in.repeat_res = q_item.repeat_res;
      result_in.image_done = q_item.image_done;

      out_valid  = valid_ff;
      out_result = result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tga_rle_pixel_decoder_top.sv
// -----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Decodes the run-length-encoded pixel stream of a TGA image.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel: one compressed byte per transaction on req_data_byte,
//   taken when req_push is high and req_full is low.
//   Result channel: one decoded pixel per transaction; the oldest result sits
//   on the rsp_ ports while rsp_empty is low and is taken with rsp_pop.
//   A run packet yields a single result with rsp_repeat_res set to its
//   length, clamped to the pixels still missing; rsp_image_done marks the
//   last pixel of the image, after which the next byte is a packet header.
//   Header bytes and non-final pixel bytes give no result.
//   Throughput: one byte per cycle while req_full is low; the parser updates
//   all of its state with each accepted byte. A completed pixel is written
//   into the queue and is loaded from there into the output register, where
//   it can be taken with rsp_pop.
//   When the receiver stalls, results collect in a QUEUE_DEPTH-entry queue
//   plus the output register; req_full rises once the queue fills.
//   Reset (synchronous) clears the parser, the queue and the output register
//   and loads bytes_per_pixel = 3, pixel_total = 1. Write the csr_ registers
//   only while the block is idle.
// -----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_top
   import trld_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic [7:0]       rsp_repeat_res,
   output logic             rsp_image_done,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   trld_cfg_type    cfg_ff, cfg_in;
   logic            accept;
   logic            item_valid;
   trld_item_type   item;
   trld_item_type   q_item;
   logic            q_full;
   logic            q_empty;
   logic            q_pop;
   logic            out_valid;
   trld_result_type out_result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_data[2:0];
            CSR_PIXEL_TOTAL:     cfg_in.pixel_total     = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= BPP_RESET;
         cfg_ff.pixel_total     <= TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   trld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .item_valid (item_valid),
      .item       (item)
   );

   trld_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (item_valid),
      .wr_item (item),
      .rd_en   (q_pop),
      .rd_item (q_item),
      .full    (q_full),
      .empty   (q_empty)
   );

   trld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .out_pop    (rsp_pop),
      .out_valid  (out_valid),
      .out_result (out_result)
   );

   assign rsp_empty      = !out_valid;
   assign rsp_red        = out_result.red;
   assign rsp_green      = out_result.green;
   assign rsp_blue       = out_result.blue;
   assign rsp_alpha      = out_result.alpha;
   assign rsp_repeat_res = out_result.repeat_res;
   assign rsp_image_done = out_result.image_done;

endmodule

`default_nettype wire

// File: rtl/trld_checker.sv
// -----------------------------------------------------------------------------
// trld_checker
// Port-level checks of the decoder, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module trld_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_full,
   input  wire logic       rsp_empty,
   input  wire logic       rsp_pop,
   input  wire logic [7:0] rsp_red,
   input  wire logic [7:0] rsp_repeat_res,
   input  wire logic       rsp_image_done
);

   // stalled result transaction holds
   `ASSERT_CLK(a_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_red) && $stable(rsp_repeat_res) && $stable(rsp_image_done))

   // a run never reports zero or more than a full packet
   `ASSERT_CLK(a_repeat_range, clock, reset, !rsp_empty |-> rsp_repeat_res != 8'd0 && rsp_repeat_res <= 8'd128)

   // the queue cannot fill while the output register is empty
   `ASSERT_CLK(a_full_needs_out, clock, reset, rsp_empty |-> !req_full)

   // reset empties both sides
   `ASSERT_ALWAYS(a_reset_clear, clock, reset |=> rsp_empty && !req_full)

endmodule

bind tga_rle_pixel_decoder_top trld_checker u_trld_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_red        (rsp_red),
   .rsp_repeat_res (rsp_repeat_res),
   .rsp_image_done (rsp_image_done)
);

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TGA run-length pixel decoder. A short table of
// packets covers the pixel sizes, run and raw packets, value extremes and
// image-end clamping. Random phases follow, each with its own register
// setting. Every accepted byte is fed to a bit-exact predictor, and each
// popped pixel is compared field by field against the oldest prediction.
// -----------------------------------------------------------------------------

module testbench;
   import trld_pkg::*;

   localparam int          RANDOM_PHASES   = 12;
   localparam int          BYTES_PER_PHASE = 100;
   localparam int          SETTLE_CYCLES   = 6;
   localparam int          QUIET_LIMIT     = 1000;
   localparam logic [31:0] HUGE_TOTAL      = 32'hFFFE_0001;

   typedef enum logic [0:0] {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [1:0]      index;
      logic [31:0]     value;
      bit              typed;
      trld_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_push         = 1'b0;
   logic [7:0]  req_data_byte    = 8'd0;
   logic        rsp_pop          = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = CSR_BYTES_PER_PIXEL;
   logic [31:0] csr_data         = 32'd0;
   logic        req_full;
   logic        rsp_empty;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_res;
   logic        rsp_image_done;

   // Predictor copy of the registers and the parser state
   logic [2:0]  px_size_reg   = BPP_RESET;
   logic [31:0] total_reg     = TOTAL_RESET;
   logic        in_pkt        = 1'b0;
   logic        pkt_is_run    = 1'b0;
   logic [7:0]  pkt_left      = 8'd0;
   logic [1:0]  byte_slot     = 2'd0;
   logic [7:0]  held_bytes [0:2] = '{8'd0, 8'd0, 8'd0};
   logic [31:0] image_pixels  = 32'd0;

   trld_result_type expected_pixels [$];

   int mismatches      = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int images_closed   = 0;
   int csr_writes      = 0;
   int idle_pct        = 0;
   int stall_pct       = 0;
   int stall_left      = 0;
   int quiet_cycles    = 0;

   tga_rle_pixel_decoder_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_res   (rsp_repeat_res),
      .rsp_image_done   (rsp_image_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the parser by one byte; returns 1 when the byte completes a pixel.
   function automatic bit decode_byte(input logic [7:0] b, output trld_result_type px);
      logic [2:0]  size;
      logic [31:0] count;
      logic [31:0] remaining;
      logic [31:0] span;
      logic        last;
      px = '0;
      size = (px_size_reg == WIDE_PIXEL) ? WIDE_PIXEL : NARROW_PIXEL;
      if (!in_pkt) begin
         pkt_is_run = (b >= RUN_FLAG);
         pkt_left   = pkt_is_run ? b - RUN_BIAS : b + 8'd1;
         byte_slot  = 2'd0;
         in_pkt     = 1'b1;
         return 1'b0;
      end
      if (32'(byte_slot) + 32'd1 < 32'(size)) begin
         if (byte_slot < 2'd3) held_bytes[byte_slot] = b;
         byte_slot = byte_slot + 2'd1;
         return 1'b0;
      end
      px.red   = (size == WIDE_PIXEL) ? held_bytes[2] : b;
      px.alpha = (size == WIDE_PIXEL) ? b : 8'd0;
      px.green = held_bytes[1];
      px.blue  = held_bytes[0];
      count = pkt_is_run ? 32'(pkt_left) : 32'd1;
      if (count == 32'd0) count = 32'd1;
      // clamp to the pixels still missing; a total already reached acts as one
      remaining = (total_reg > image_pixels) ? total_reg - image_pixels : 32'd1;
      span = (count < remaining) ? count : remaining;
      last = (span >= remaining);
      px.repeat_res = span[7:0];
      px.image_done = last;
      byte_slot = 2'd0;
      if (last) begin
         in_pkt       = 1'b0;
         pkt_is_run   = 1'b0;
         pkt_left     = 8'd0;
         image_pixels = 32'd0;
      end else begin
         image_pixels = image_pixels + span;
         if (pkt_is_run) begin
            in_pkt   = 1'b0;
            pkt_left = 8'd0;
         end else begin
            pkt_left = pkt_left - 8'd1;
            if (pkt_left == 8'd0) in_pkt = 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Mostly well-formed packets with random content, some noise headers.
   function automatic logic [7:0] next_byte();
      if ($urandom_range(0, 99) < 8) return 8'($urandom_range(0, 255));
      if (in_pkt) return 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) return RUN_FLAG + 8'($urandom_range(0, 127));
      if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 7));
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic stim_row_type byte_row(input logic [7:0] b);
      stim_row_type row;
      row = '{ROW_BYTE, CSR_BYTES_PER_PIXEL, 32'(b), 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type pixel_row(input logic [7:0] b, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] bl,
                                              input logic [7:0] a, input logic [7:0] rep,
                                              input logic done);
      stim_row_type row;
      row = '{ROW_BYTE, CSR_BYTES_PER_PIXEL, 32'(b), 1'b1, '0};
      row.want = '{red: r, green: g, blue: bl, alpha: a, repeat_res: rep, image_done: done};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [1:0] index, input logic [31:0] value);
      stim_row_type row;
      row = '{ROW_CSR, index, value, 1'b0, '0};
      return row;
   endfunction

   task automatic maybe_idle();
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Hold the byte until taken, then predict; a typed row overrides the prediction.
   task automatic push_byte(input logic [7:0] b, input bit typed, input trld_result_type want);
      trld_result_type px;
      bit              produced;
      req_push      <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
      produced = decode_byte(b, px);
      if (typed || produced) expected_pixels.push_back(typed ? want : px);
      maybe_idle();
   endtask

   // Drop the request and wait for every pending pixel plus pipeline slack.
   task automatic settle();
      req_push <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_BYTES_PER_PIXEL) px_size_reg = value[2:0];
      else if (index == CSR_PIXEL_TOTAL) total_reg = value;
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_pixel();
      trld_result_type want;
      if (expected_pixels.size() == 0) begin
         $error("pixel with nothing pending: red %0h green %0h blue %0h repeat %0d",
                rsp_red, rsp_green, rsp_blue, rsp_repeat_res);
         mismatches++;
         return;
      end
      want = expected_pixels.pop_front();
      check_field("red", want.red, rsp_red);
      check_field("green", want.green, rsp_green);
      check_field("blue", want.blue, rsp_blue);
      check_field("alpha", want.alpha, rsp_alpha);
      check_field("repeat_res", want.repeat_res, rsp_repeat_res);
      check_field("image_done", 8'(want.image_done), 8'(rsp_image_done));
      results_checked++;
      if (want.image_done) images_closed++;
   endtask

   // Result side: check each popped transaction, stall in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop    <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) check_pixel();
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_pop    <= 1'b0;
         end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 7);
            rsp_pop    <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type plan [$];
      logic [31:0] value;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 24-bit run of one pixel after reset: total of one closes the image
      plan.push_back(byte_row(8'h80));
      plan.push_back(byte_row(8'h00));
      plan.push_back(byte_row(8'hFF));
      plan.push_back(pixel_row(8'h5A, 8'h5A, 8'hFF, 8'h00, 8'h00, 8'd1, 1'b1));
      // longest run of an all-ones 32-bit pixel in an image of HUGE_TOTAL pixels
      plan.push_back(csr_row(CSR_BYTES_PER_PIXEL, 32'(WIDE_PIXEL)));
      plan.push_back(csr_row(CSR_PIXEL_TOTAL, HUGE_TOTAL));
      plan.push_back(byte_row(8'hFF));
      plan.push_back(byte_row(8'hFF));
      plan.push_back(byte_row(8'hFF));
      plan.push_back(byte_row(8'hFF));
      plan.push_back(pixel_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd128, 1'b0));
      // raw packet of two; shrink the pixel size after its third pixel byte
      plan.push_back(byte_row(8'h01));
      plan.push_back(byte_row(8'h11));
      plan.push_back(byte_row(8'h22));
      plan.push_back(byte_row(8'h33));
      plan.push_back(csr_row(CSR_BYTES_PER_PIXEL, 32'(NARROW_PIXEL)));
      plan.push_back(byte_row(8'h44));
      // unsupported size acts as 24-bit; total below the pixels already done
      plan.push_back(csr_row(CSR_BYTES_PER_PIXEL, 32'hFFFF_FFF7));
      plan.push_back(csr_row(CSR_PIXEL_TOTAL, 32'd2));
      plan.push_back(byte_row(8'hA1));
      plan.push_back(byte_row(8'hB2));
      plan.push_back(byte_row(8'hC3));
      // zero total: raw packet of three ends the image after its first pixel
      plan.push_back(csr_row(CSR_BYTES_PER_PIXEL, 32'hA5A5_A5A0));
      plan.push_back(csr_row(CSR_PIXEL_TOTAL, 32'd0));
      plan.push_back(byte_row(8'h02));
      plan.push_back(byte_row(8'h10));
      plan.push_back(byte_row(8'h20));
      plan.push_back(byte_row(8'h30));
      plan.push_back(byte_row(8'h80));
      plan.push_back(byte_row(8'h7F));
      plan.push_back(byte_row(8'h80));
      plan.push_back(byte_row(8'h01));

      idle_pct  = 25;
      stall_pct = 25;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_csr(plan[i].index, plan[i].value);
         end else begin
            push_byte(plan[i].value[7:0], plan[i].typed, plan[i].want);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case ($urandom_range(0, 9))
            0, 1, 2, 3: value = {$urandom_range(0, 1) ? 29'h1FFF_FFFF : 29'd0, NARROW_PIXEL};
            4, 5, 6, 7: value = {$urandom_range(0, 1) ? 29'h1FFF_FFFF : 29'd0, WIDE_PIXEL};
            default:    value = $urandom;
         endcase
         write_csr(CSR_BYTES_PER_PIXEL, value);
         case ($urandom_range(0, 9))
            0:             value = 32'd1;
            1, 2, 3, 4:    value = 32'($urandom_range(2, 40));
            5, 6:          value = 32'($urandom_range(41, 600));
            7:             value = 32'd0;
            8:             value = HUGE_TOTAL;
            default:       value = $urandom;
         endcase
         write_csr(CSR_PIXEL_TOTAL, value);
         if (p == RANDOM_PHASES - 1) begin
            // last phase runs at full rate on both sides
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               default: idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               default: stall_pct = 35;
            endcase
         end
         for (int k = 0; k < BYTES_PER_PHASE; k++) push_byte(next_byte(), 1'b0, '0);
      end

      settle();
      $display("Covered %0d compressed bytes and %0d register writes over %0d phases",
               bytes_sent, csr_writes, RANDOM_PHASES + 1);
      $display("Checked %0d decoded pixels, %0d of them closing an image",
               results_checked, images_closed);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
